// ===== sv/twcr_pkg.sv =====
// ----------------------------------------------------------------------------
// twcr_pkg
// Shared constants and types for the textured wall column renderer.
// ----------------------------------------------------------------------------
package twcr_pkg;

  // default geometry
  localparam int SCREEN_HEIGHT_DEF    = 480;
  localparam int TEXTURE_MAX_SIDE_DEF = 64;

  // divider width: covers the Q16.8 ray length and the Q7.16 step numerator
  localparam int DIV_W = 24;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_CEILING_COLOR  = 2'd0;
  localparam logic [1:0] REG_FLOOR_COLOR    = 2'd1;
  localparam logic [1:0] REG_TEXTURE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_TEXTURE_HEIGHT = 2'd3;

  localparam logic [6:0] TEXTURE_SIDE_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_PIXEL = 2'd2
  } cmd_e;

endpackage

// ===== sv/twcr_ram.sv =====
// ----------------------------------------------------------------------------
// twcr_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module twcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/twcr_div.sv =====
// ----------------------------------------------------------------------------
// twcr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twcr_div
  import twcr_pkg::*;
#(
  parameter int W = DIV_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] quot_o,
  output logic         done_o
);

  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     quo_q;
  logic [W-1:0]     rem_q;
  logic [W-1:0]     den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       fits;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      quo_q  <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract where the divisor fits
      rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], fits};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// ===== sv/textured_wall_column_render_unit.sv =====
// ----------------------------------------------------------------------------
// textured_wall_column_render_unit
// Load word: written into texture memory at acceptance.
// Pixel word: a texture read on wall rows, then the output register once free.
// Begin word: wall height, then texture step, from the shared
//   one-bit-per-cycle divider; a zero length skips the height division.
// Reset: asynchronous; registers to reset values, no column active; the
//   texture memory is not cleared.
// ----------------------------------------------------------------------------
module textured_wall_column_render_unit
  import twcr_pkg::*;
#(
  parameter int SCREEN_HEIGHT    = SCREEN_HEIGHT_DEF,
  parameter int TEXTURE_MAX_SIDE = TEXTURE_MAX_SIDE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [11:0]           texel_index_i,
  input  logic [31:0]           texel_value_i,
  input  logic [23:0]           ray_length_i,
  input  logic [15:0]           hit_frac_i,
  input  logic [9:0]            screen_column_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           pixel_color_o,
  output logic [8:0]            pixel_row_o,
  output logic [9:0]            pixel_column_o,
  output logic                  last_row_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int STORE_DEPTH = TEXTURE_MAX_SIDE * TEXTURE_MAX_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(SCREEN_HEIGHT);
  // wall height reaches SCREEN_HEIGHT*256 for the shortest nonzero ray
  localparam int H_W         = $clog2(SCREEN_HEIGHT * 256 + 1);
  localparam int HALF_W      = H_W - 1;
  localparam int MID         = SCREEN_HEIGHT / 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_HSTART,
    S_HWAIT,
    S_SSTART,
    S_SWAIT,
    S_POS
  } state_e;

  // what the pixel in flight shows
  typedef enum logic [1:0] {
    K_CEIL,
    K_WALL,
    K_FLOOR,
    K_BLANK
  } kind_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] ceil_color_q;
  logic [31:0] floor_color_q;
  logic [6:0]  tw_q;
  logic [6:0]  th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_color_q  <= '0;
      floor_color_q <= '0;
      tw_q          <= TEXTURE_SIDE_RESET;
      th_q          <= TEXTURE_SIDE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CEILING_COLOR:  ceil_color_q  <= pwdata;
        REG_FLOOR_COLOR:    floor_color_q <= pwdata;
        REG_TEXTURE_WIDTH:  tw_q          <= pwdata[6:0];
        REG_TEXTURE_HEIGHT: th_q          <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CEILING_COLOR:  prdata = ceil_color_q;
      REG_FLOOR_COLOR:    prdata = floor_color_q;
      REG_TEXTURE_WIDTH:  prdata = {25'b0, tw_q};
      REG_TEXTURE_HEIGHT: prdata = {25'b0, th_q};
      default:            prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // --------------------------------------------------------------------------
  // Column state
  // --------------------------------------------------------------------------
  state_e            state_q;
  logic              col_active_q;
  logic [ROW_W-1:0]  cur_row_q;
  logic [9:0]        cur_col_q;
  logic [ROW_W-1:0]  start_row_q;
  logic [ROW_W-1:0]  end_row_q;
  logic [6:0]        tex_col_q;
  logic [31:0]       pos_q;
  logic [31:0]       step_q;
  logic [23:0]       len_q;
  logic [H_W-1:0]    h_q;
  logic              start_neg_q;
  logic [HALF_W-1:0] start_mag_q;

  // pixel in flight and output register
  kind_e             kind_q;
  logic [8:0]        pix_row_q;
  logic              pix_last_q;
  logic              out_valid_q;
  logic [31:0]       out_color_q;
  logic [8:0]        out_row_q;
  logic [9:0]        out_col_q;
  logic              out_last_q;

  logic in_accept;
  cmd_e cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(command_i);

  // output register takes the pixel in flight this cycle
  logic out_load;
  assign out_load = (state_q == S_FETCH) && (!out_valid_q || out_ready_i);

  // --------------------------------------------------------------------------
  // Texture fetch address for the current row
  // --------------------------------------------------------------------------
  logic [6:0]  tex_y;
  logic [13:0] row_off;
  logic [13:0] fetch_addr;
  logic [13:0] tex_bound;
  logic        fetch_ok;

  assign tex_y      = pos_q[22:16] & (th_q - 7'd1);
  assign row_off    = tex_y * tw_q;
  assign fetch_addr = row_off + {7'b0, tex_col_q};
  assign tex_bound  = tw_q * th_q;
  assign fetch_ok   = (fetch_addr < tex_bound) && (32'(fetch_addr) < 32'(STORE_DEPTH));

  logic row_is_ceil;
  logic row_is_wall;
  logic row_is_last;
  logic [ROW_W+8:0] row_ext;

  assign row_is_ceil = cur_row_q < start_row_q;
  assign row_is_wall = !row_is_ceil && (cur_row_q <= end_row_q);
  assign row_is_last = cur_row_q == ROW_W'(SCREEN_HEIGHT - 1);
  assign row_ext     = {9'b0, cur_row_q};

  logic pixel_go;
  assign pixel_go = in_accept && (cmd == CMD_PIXEL) && col_active_q;

  // --------------------------------------------------------------------------
  // Texture memory
  // --------------------------------------------------------------------------
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  assign ram_we    = in_accept && (cmd == CMD_LOAD) &&
                     (32'(texel_index_i) < 32'(STORE_DEPTH));
  assign ram_waddr = ADDR_W'(texel_index_i);
  assign ram_re    = pixel_go && row_is_wall && fetch_ok;
  assign ram_raddr = ADDR_W'(fetch_addr);

  twcr_ram #(
    .WIDTH (32),
    .DEPTH (STORE_DEPTH)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (texel_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared divider: wall height, then texture step
  // --------------------------------------------------------------------------
  logic             div_start;
  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic [DIV_W-1:0] div_quot;
  logic             div_done;

  assign div_start = (state_q == S_HSTART) || (state_q == S_SSTART);
  assign div_num   = (state_q == S_HSTART) ? DIV_W'(SCREEN_HEIGHT * 256)
                                           : DIV_W'({th_q, 16'b0});
  assign div_den   = (state_q == S_HSTART) ? DIV_W'(len_q) : DIV_W'(h_q);

  twcr_div #(
    .W (DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  // --------------------------------------------------------------------------
  // Wall span from height: start may fall above the screen
  // --------------------------------------------------------------------------
  logic [HALF_W-1:0] half;
  logic [H_W:0]      start_diff;
  logic [H_W-1:0]    end_sum;
  logic [ROW_W-1:0]  start_row_d;
  logic [ROW_W-1:0]  end_row_d;
  logic [HALF_W-1:0] start_mag_d;
  logic [H_W+30:0]   pos_prod;

  assign half        = h_q[H_W-1:1];
  // start row as MID - half; the top bit flags a start above the screen
  assign start_diff  = (H_W+1)'(MID) - {2'b0, half};
  assign end_sum     = {1'b0, half} + H_W'(MID);
  assign start_mag_d = half - HALF_W'(MID);
  assign start_row_d = start_diff[H_W] ? '0 : start_diff[ROW_W-1:0];
  assign end_row_d   = (end_sum >= H_W'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 1)
                                                        : end_sum[ROW_W-1:0];
  assign pos_prod    = start_mag_q * step_q;

  logic [22:0] strike_prod;
  assign strike_prod = hit_frac_i * tw_q;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      col_active_q <= 1'b0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      start_row_q  <= '0;
      end_row_q    <= '0;
      tex_col_q    <= '0;
      pos_q        <= '0;
      step_q       <= '0;
      len_q        <= '0;
      h_q          <= '0;
      start_neg_q  <= 1'b0;
      start_mag_q  <= '0;
      kind_q       <= K_CEIL;
      pix_row_q    <= '0;
      pix_last_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_color_q  <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      // drop the output word once taken, unless a new one moves in
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            case (cmd)
              CMD_BEGIN: begin
                len_q     <= ray_length_i;
                cur_col_q <= screen_column_i;
                tex_col_q <= strike_prod[22:16];
                if (ray_length_i == '0) begin
                  h_q     <= H_W'(SCREEN_HEIGHT);
                  state_q <= S_SSTART;
                end else begin
                  state_q <= S_HSTART;
                end
              end
              CMD_PIXEL: begin
                if (col_active_q) begin
                  pix_row_q  <= row_ext[8:0];
                  pix_last_q <= row_is_last;
                  if (row_is_ceil) begin
                    kind_q <= K_CEIL;
                  end else if (row_is_wall) begin
                    kind_q <= fetch_ok ? K_WALL : K_BLANK;
                    pos_q  <= pos_q + step_q;
                  end else begin
                    kind_q <= K_FLOOR;
                  end
                  // advance the row, close the column after the bottom row
                  if (row_is_last) begin
                    cur_row_q    <= '0;
                    col_active_q <= 1'b0;
                  end else begin
                    cur_row_q <= cur_row_q + 1'b1;
                  end
                  state_q <= S_FETCH;
                end
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          // hold the fetched texel until the output register is free
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_row_q   <= pix_row_q;
            out_col_q   <= cur_col_q;
            out_last_q  <= pix_last_q;
            case (kind_q)
              K_CEIL:  out_color_q <= ceil_color_q;
              K_WALL:  out_color_q <= ram_rdata;
              K_FLOOR: out_color_q <= floor_color_q;
              default: out_color_q <= '0;
            endcase
            state_q <= S_IDLE;
          end
        end
        S_HSTART: begin
          state_q <= S_HWAIT;
        end
        S_HWAIT: begin
          if (div_done) begin
            // clamp a zero height to one row
            h_q     <= (div_quot == '0) ? H_W'(1) : div_quot[H_W-1:0];
            state_q <= S_SSTART;
          end
        end
        S_SSTART: begin
          start_row_q <= start_row_d;
          end_row_q   <= end_row_d;
          start_neg_q <= start_diff[H_W];
          start_mag_q <= start_mag_d;
          state_q     <= S_SWAIT;
        end
        S_SWAIT: begin
          if (div_done) begin
            step_q  <= {{(32 - DIV_W){1'b0}}, div_quot};
            state_q <= S_POS;
          end
        end
        S_POS: begin
          // skip the texture rows that lie above the screen
          pos_q        <= start_neg_q ? pos_prod[31:0] : '0;
          cur_row_q    <= '0;
          col_active_q <= 1'b1;
          state_q      <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_color_o  = out_color_q;
  assign pixel_row_o    = out_row_q;
  assign pixel_column_o = out_col_q;
  assign last_row_o     = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ram_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("texture memory written and read in one cycle");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_HWAIT || state_q == S_SWAIT))
    else $error("divider finished outside a wait state");

  a_begin_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POS) |=> (col_active_q && state_q == S_IDLE && cur_row_q == '0))
    else $error("column setup did not open the column at its top row");

  a_fetch_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("pixel fetch did not fill the output register");

  a_row_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_active_q |-> (cur_row_q <= ROW_W'(SCREEN_HEIGHT - 1)))
    else $error("current row beyond the screen");

endmodule

// ===== tb/textured_wall_column_render_unit_tb.sv =====
// ----------------------------------------------------------------------------
// textured_wall_column_render_unit_tb
// Drives texture loads, column setups and pixel requests into the wall column
// renderer and checks every emitted pixel against a cycle-free column model
// kept here. Both handshake sides idle at random; one phase holds the pixel
// side off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module textured_wall_column_render_unit_tb;
  import twcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;
  typedef int unsigned     u32_t;

  localparam int SCREEN_H      = SCREEN_HEIGHT_DEF;
  localparam int STORE_DEPTH   = TEXTURE_MAX_SIDE_DEF * TEXTURE_MAX_SIDE_DEF;
  // every texture window used here spans at most this many texels
  localparam int FILL_TEXELS   = 16;
  // long enough for a begin word to finish inside the block
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  // command code the block ignores
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  typedef struct packed {
    logic [31:0] color;
    logic [8:0]  row;
    logic [9:0]  col;
    logic        last;
  } pixel_t;

  // DUT signals; the inputs are all known from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = '0;
  logic [11:0] texel_index = '0;
  logic [31:0] texel_value = '0;
  logic [23:0] ray_length = '0;
  logic [15:0] hit_frac = '0;
  logic [9:0]  screen_column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pixel_color;
  logic [8:0]  pixel_row;
  logic [9:0]  pixel_column;
  logic        last_row;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;

  // Column model state
  logic [31:0] tex_mem [STORE_DEPTH];
  logic [31:0] ceil_color = '0;
  logic [31:0] floor_color = '0;
  logic [6:0]  tex_width = TEXTURE_SIDE_RESET;
  logic [6:0]  tex_height = TEXTURE_SIDE_RESET;
  int          col_start = 0;
  int          col_end = 0;
  logic [6:0]  tex_col = '0;
  logic [31:0] tex_pos = '0;
  logic [31:0] tex_inc = '0;
  int          cur_row = 0;
  logic [9:0]  cur_col = '0;
  bit          col_active = 1'b0;

  pixel_t pending_pixels[$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  pixels_checked = 0;
  int  columns_done = 0;
  int  settings_used = 0;
  bit  src_calm = 1'b0;
  bit  sink_calm = 1'b0;
  int  sink_hold = 0;

  always #5 clk_i = ~clk_i;

  textured_wall_column_render_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .command_i       (command),
    .texel_index_i   (texel_index),
    .texel_value_i   (texel_value),
    .ray_length_i    (ray_length),
    .hit_frac_i      (hit_frac),
    .screen_column_i (screen_column),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .pixel_color_o   (pixel_color),
    .pixel_row_o     (pixel_row),
    .pixel_column_o  (pixel_column),
    .last_row_o      (last_row),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // --------------------------------------------------------------------------
  // Column model
  // --------------------------------------------------------------------------

  // Fetch the texel under the current texture position; anything outside
  // the width x height window reads as zero. A zero height gives a full
  // mask and an empty window, so every wall row comes out black.
  function automatic logic [31:0] texel_at();
    logic [6:0] mask;
    u32_t       ty;
    u32_t       addr;
    mask = tex_height - 7'd1;
    ty   = (tex_pos >> 16) & u32_t'(mask);
    addr = ty * u32_t'(tex_width) + u32_t'(tex_col);
    if (addr >= u32_t'(tex_width) * u32_t'(tex_height) || addr >= STORE_DEPTH)
      return '0;
    return tex_mem[addr];
  endfunction

  // Set up wall height, clipped rows, texture column, step and start point.
  function automatic void setup_column(input logic [23:0] len, input logic [15:0] strike,
                                       input logic [9:0] col);
    u32_t h;
    int   half;
    int   top;
    int   bottom;
    // zero length means the wall fills the screen
    if (len == '0) h = SCREEN_H;
    else h = u32_t'(SCREEN_H * 256) / u32_t'(len);
    // far walls still draw one row
    if (h < 1) h = 1;
    half   = int'(h / 2);
    top    = SCREEN_H / 2 - half;
    bottom = SCREEN_H / 2 + half;
    if (bottom >= SCREEN_H) bottom = SCREEN_H - 1;
    tex_col  = 7'((u64_t'(strike) * u64_t'(tex_width)) >> 16);
    tex_inc  = 32'((u64_t'(tex_height) << 16) / u64_t'(h));
    // wall taller than the screen: skip the texture rows above row 0
    if (top < 0) begin
      tex_pos = 32'(u64_t'(-top) * u64_t'(tex_inc));
      top = 0;
    end else begin
      tex_pos = '0;
    end
    col_start  = top;
    col_end    = bottom;
    cur_row    = 0;
    cur_col    = col;
    col_active = 1'b1;
  endfunction

  // Produce the next row of the active column and queue it for the checker.
  function automatic void emit_row();
    pixel_t px;
    int     row;
    row = cur_row;
    if (row < col_start) begin
      px.color = ceil_color;
    end else if (row <= col_end) begin
      px.color = texel_at();
      tex_pos += tex_inc;
    end else begin
      px.color = floor_color;
    end
    px.row  = 9'(row);
    px.col  = cur_col;
    px.last = (row + 1 >= SCREEN_H);
    if (px.last) begin
      col_active = 1'b0;
      cur_row = 0;
      columns_done++;
    end else begin
      cur_row = row + 1;
    end
    pending_pixels.push_back(px);
  endfunction

  // Apply one accepted word to the column model.
  function automatic void render_word(input logic [1:0] cmd, input logic [11:0] idx,
                                      input logic [31:0] val, input logic [23:0] len,
                                      input logic [15:0] strike, input logic [9:0] col);
    case (cmd)
      CMD_LOAD:  tex_mem[idx] = val;
      CMD_BEGIN: setup_column(len, strike, col);
      CMD_PIXEL: if (col_active) emit_row();
      default:   ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Handshake helpers
  // --------------------------------------------------------------------------

  // Unless calm, half go back to back and the rest wait a short or long gap.
  function automatic int draw_gap(input bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return $urandom_range(1, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  // Offer one word and hold it until accepted, then update the model. Valid
  // stays high on return so a following word can go out back to back.
  task automatic send_word(input logic [1:0] cmd, input logic [11:0] idx,
                           input logic [31:0] val, input logic [23:0] len,
                           input logic [15:0] strike, input logic [9:0] col);
    int gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command       <= cmd;
    texel_index   <= idx;
    texel_value   <= val;
    ray_length    <= len;
    hit_frac      <= strike;
    screen_column <= col;
    in_valid      <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    words_sent++;
    render_word(cmd, idx, val, len, strike, col);
  endtask

  // Pixel request; the unused fields carry noise.
  task automatic send_pixel();
    send_word(CMD_PIXEL, 12'($urandom), $urandom, 24'($urandom), 16'($urandom),
              10'($urandom));
  endtask

  // Drop valid, wait for every queued pixel, then let a begin word finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write a register over APB, mirror it in the model, then read it back.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] readback;
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_CEILING_COLOR:  begin ceil_color = data;       want = data; end
      REG_FLOOR_COLOR:    begin floor_color = data;      want = data; end
      REG_TEXTURE_WIDTH:  begin tex_width = data[6:0];   want = {25'b0, data[6:0]}; end
      default:            begin tex_height = data[6:0];  want = {25'b0, data[6:0]}; end
    endcase
    // read access right behind the write
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (readback !== want) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, idx, want,
               readback);
      mismatches++;
    end
  endtask

  task automatic apply_setting(input logic [31:0] c, input logic [31:0] f,
                               input logic [6:0] w, input logic [6:0] h);
    settle();
    cfg_write(REG_CEILING_COLOR, c);
    cfg_write(REG_FLOOR_COLOR, f);
    cfg_write(REG_TEXTURE_WIDTH, {25'b0, w});
    cfg_write(REG_TEXTURE_HEIGHT, {25'b0, h});
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Pixel side: random ready pauses, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : pixel_sink
    int pause;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        pause = sink_hold;
        sink_hold = 0;
      end else begin
        pause = draw_gap(sink_calm);
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare every accepted pixel with the oldest queued one.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none actual row %0d col %0d color %h",
                 $time, pixel_row, pixel_column, pixel_color);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_color", want.color, pixel_color);
        check_field("pixel_row", 32'(want.row), 32'(pixel_row));
        check_field("pixel_column", 32'(want.col), 32'(pixel_column));
        check_field("last_row", 32'(want.last), 32'(last_row));
        pixels_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Write the texels that every texture window below covers, so no wall
  // fetch ever hits an unwritten entry.
  task automatic test_texture_fill();
    int i;
    for (i = 0; i < FILL_TEXELS; i++)
      send_word(CMD_LOAD, 12'(i), $urandom, 24'($urandom), 16'($urandom), 10'($urandom));
  endtask

  // Field extremes, every command and the named corner cases.
  task automatic test_directed_cases();
    apply_setting(32'hFFFF_FFFF, 32'h0000_0000, 7'd4, 7'd4);
    // pixel before any column: no output
    send_pixel();
    // reserved command: ignored
    send_word(CMD_RESERVED, 12'hFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 10'h3FF);
    send_word(CMD_LOAD, 12'hFFF, 32'hFFFF_FFFF, 24'h0, 16'h0, 10'h0);
    send_word(CMD_LOAD, 12'h000, 32'h0000_0000, 24'hFF_FFFF, 16'hFFFF, 10'h3FF);
    // zero length: full-screen wall, last texture column
    send_word(CMD_BEGIN, 12'h0, 32'h0, 24'h0, 16'hFFFF, 10'h3FF);
    repeat (3) send_pixel();
    // exactly screen height, texel 0
    send_word(CMD_BEGIN, 12'hFFF, 32'hFFFF_FFFF, 24'd256, 16'h0, 10'h0);
    repeat (2) send_pixel();
    // shortest length: huge wall, start row far above the screen
    send_word(CMD_BEGIN, 12'h0, 32'h0, 24'd1, 16'h8000, 10'd200);
    repeat (2) send_pixel();
    // longest length: quotient zero, clamped to one wall row
    send_word(CMD_BEGIN, 12'h0, 32'h0, 24'hFF_FFFF, 16'h0001, 10'd1);
    repeat (2) send_pixel();
  endtask

  // One whole column while the pixel side stalls; the extra requests after
  // the bottom row must produce nothing.
  task automatic test_backpressure_full_column();
    int i;
    settle();
    src_calm  = 1'b1;
    sink_hold = HOLD_CYCLES;
    send_word(CMD_BEGIN, 12'($urandom), $urandom, 24'($urandom_range(200, 700)),
              16'($urandom), 10'($urandom));
    for (i = 0; i < SCREEN_H + 2; i++) send_pixel();
    src_calm = 1'b0;
    settle();
  endtask

  // Lengths weighted toward walls that start high, with full-range noise.
  function automatic logic [23:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 24'd0;
      1:       return 24'($urandom_range(1, 64));
      2, 3, 4, 5: return 24'($urandom_range(65, 600));
      6:       return 24'($urandom_range(601, 4000));
      7, 8:    return 24'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 24'd1;
          1:       return 24'hFF_FFFF;
          2:       return 24'd256;
          default: return 24'd257;
        endcase
      end
    endcase
  endfunction

  // Mostly begin-then-pixels sequences, the rest stray words.
  task automatic run_phase(input logic [31:0] c, input logic [31:0] f,
                           input logic [6:0] w, input logic [6:0] h,
                           input bit calm, input int budget);
    int first;
    int n;
    int k;
    apply_setting(c, f, w, h);
    src_calm  = calm;
    sink_calm = calm;
    first = words_sent;
    while (words_sent - first < budget) begin
      if ($urandom_range(0, 3) != 0) begin
        send_word(CMD_BEGIN, 12'($urandom), $urandom, pick_length(), 16'($urandom),
                  10'($urandom));
        n = $urandom_range(0, 12);
        for (k = 0; k < n; k++) send_pixel();
      end else begin
        case ($urandom_range(0, 2))
          0: send_word(CMD_LOAD, 12'($urandom), $urandom, 24'($urandom), 16'($urandom),
                       10'($urandom));
          1: send_word(CMD_RESERVED, 12'($urandom), $urandom, 24'($urandom),
                       16'($urandom), 10'($urandom));
          default: send_pixel();
        endcase
      end
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_phase($urandom, $urandom, 7'd16, 7'd1, 1'b0, 6);
    // no idling on either side here
    run_phase(32'hFFFF_FFFF, 32'h0000_0000, 7'd2, 7'd8, 1'b1, 6);
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 7'd1, 7'd1, 1'b0, 6);
    // height not a power of two
    run_phase($urandom, $urandom, 7'd5, 7'd3, 1'b0, 6);
    // zero height: every wall fetch reads zero
    run_phase($urandom, $urandom, 7'($urandom_range(1, 64)), 7'd0, 1'b0, 6);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_texture_fill();
    test_directed_cases();
    test_backpressure_full_column();
    test_random_traffic();
    settle();
    $display("Run covered %0d input words over %0d register settings,", words_sent,
             settings_used);
    $display("checking %0d pixels including %0d complete columns.", pixels_checked,
             columns_done);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Timeout with %0d pixels still queued", pending_pixels.size());
    $display("FAILURE");
    $finish;
  end

endmodule
